@@ rtl/core/mps_pkg.sv @@
// Shared types and constants for the maze path search block.
// Used by mps_ctrl, mps_datapath and maze_path_search; no dependencies.
package mps_pkg;

  localparam int unsigned ROW_W        = 16;
  localparam int unsigned COL_W        = 4;
  localparam int unsigned GS_W         = 5;
  localparam int unsigned MAX_SIZE_DEF = 16;
  localparam logic [GS_W-1:0] GS_RESET = 5'd16;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_RD0,
    OP_RD1,
    OP_RD2,
    OP_DOWN,
    OP_FILL_DN,
    OP_RIGHT,
    OP_BACK_L,
    OP_BACK_UP,
    OP_FILL_UP,
    OP_GOAL,
    OP_PRD,
    OP_EMIT,
    OP_NF
  } dp_op_e;

  typedef struct packed {
    logic start_open;
    logic at_goal;
    logic can_down;
    logic can_right;
    logic at_origin;
    logic came_right;
    logic emit_last;
  } dp_stat_t;

endpackage

@@ rtl/core/maze_path_search.sv @@
// Top level of the maze path search block: controller plus datapath.
// Depends on mps_pkg, mps_ctrl and mps_datapath.
//
// Rows are loaded with start/busy: a row transfers at an edge with start
// high and busy low, bit j of row_open_i marking column j open. The row
// with last_row_i set raises busy and starts a down-first, then right,
// depth-first search from the top-left to the bottom-right cell; cells
// that fail are marked dead in a working copy of the rows, dropped when
// the next search starts.
// Search: setup states RD0, RD1, RD2 read the first rows; a move within a row
// is one search step, and a move between rows adds a fill step (with one memory
// read); each cell is entered and left at most once. At the goal, the last
// path row is stored and the first is fetched, then one result per
// cycle: N results with found_o set, or one result with found_o clear.
// busy falls with the final result; the next row may follow at once.
// Each result shows for one cycle with result_valid_o; there is no stall.
// grid_size (N) is written over cfg_valid_i/cfg_ready_o while not busy.
// Reset clears control state and sets N to 16; row memories are not cleared.
module maze_path_search #(
  parameter int unsigned MAX_SIZE = mps_pkg::MAX_SIZE_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic [mps_pkg::ROW_W-1:0] row_open_i,
  input  logic                      last_row_i,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [mps_pkg::GS_W-1:0]  grid_size_i,
  output logic                      result_valid_o,
  output logic                      found_o,
  output logic [mps_pkg::ROW_W-1:0] path_row_o,
  output logic                      last_result_o
);

  mps_pkg::dp_op_e   op;
  mps_pkg::dp_stat_t stat;
  logic              cfg_we;

  assign cfg_ready_o = ~busy;
  assign cfg_we      = cfg_valid_i & cfg_ready_o;

  mps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .last_row_i (last_row_i),
    .stat_i     (stat),
    .op_o       (op),
    .busy_o     (busy)
  );

  mps_datapath #(
    .MAX_SIZE (MAX_SIZE)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .op_i           (op),
    .cfg_we_i       (cfg_we),
    .grid_size_i    (grid_size_i),
    .row_open_i     (row_open_i),
    .last_row_i     (last_row_i),
    .stat_o         (stat),
    .result_valid_o (result_valid_o),
    .found_o        (found_o),
    .path_row_o     (path_row_o),
    .last_result_o  (last_result_o)
  );

`ifndef SYNTH
  a_res_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy))
    else $error("result outside a search run");

  a_end_with_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> (result_valid_o && last_result_o))
    else $error("run ended without final result");

  a_nf_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !found_o) |-> (last_result_o && (path_row_o == '0)))
    else $error("not-found result malformed");
`endif

endmodule

@@ rtl/core/mps_datapath.sv @@
// Datapath: maze, working and path row memories, current/next row windows,
// position counters and result registers. Depends on mps_pkg.
module mps_datapath #(
  parameter int unsigned MAX_SIZE = mps_pkg::MAX_SIZE_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  mps_pkg::dp_op_e              op_i,
  input  logic                         cfg_we_i,
  input  logic [mps_pkg::GS_W-1:0]     grid_size_i,
  input  logic [mps_pkg::ROW_W-1:0]    row_open_i,
  input  logic                         last_row_i,
  output mps_pkg::dp_stat_t            stat_o,
  output logic                         result_valid_o,
  output logic                         found_o,
  output logic [mps_pkg::ROW_W-1:0]    path_row_o,
  output logic                         last_result_o
);

  localparam int unsigned ROW_W    = mps_pkg::ROW_W;
  localparam int unsigned COL_W    = mps_pkg::COL_W;
  localparam int unsigned SIDE_MAX = (MAX_SIZE < ROW_W) ? MAX_SIZE : ROW_W;
  localparam int unsigned RW       = $clog2(SIDE_MAX);
  localparam int unsigned SZW      = $clog2(SIDE_MAX + 1);
  localparam int unsigned XW       = SZW + 1;

  logic [mps_pkg::GS_W-1:0] gs_q;
  logic [SZW-1:0]           n, rowcnt_q;
  logic [XW-1:0]            n_x, r_x, c_x;
  logic [ROW_W-1:0]         cmask, mrd_m, c_bit, cur_dead, pcur_dead;
  logic [ROW_W-1:0]         cur_q, nxt_q, pcur_q;
  logic [RW-1:0]            r_q, k_q, raddr, waddr;
  logic [COL_W-1:0]         c_q;
  logic                     emit_last;

  logic [ROW_W-1:0] maze_mem [SIDE_MAX];
  logic [ROW_W-1:0] work_mem [SIDE_MAX];
  logic [ROW_W-1:0] path_mem [SIDE_MAX];
  logic [SIDE_MAX-1:0] wvld_q;
  logic [ROW_W-1:0] mrd_q, wrd_q, prd_q;
  logic             wrd_vld_q;
  logic             mwe, wwe, pwe;
  logic [ROW_W-1:0] mwdata, pwdata;

  logic             res_vld_q, found_q, last_q;
  logic [ROW_W-1:0] path_q;

  always_comb begin
    if (gs_q == '0) begin
      n = SZW'(1);
    end else if (int'(gs_q) > SIDE_MAX) begin
      n = SZW'(SIDE_MAX);
    end else begin
      n = SZW'(gs_q);
    end
  end

  assign cmask     = {ROW_W{1'b1}} >> (ROW_W - int'(n));
  assign mrd_m     = wrd_vld_q ? wrd_q : (mrd_q & cmask);
  assign n_x       = XW'(n);
  assign r_x       = XW'(r_q);
  assign c_x       = XW'(c_q);
  assign c_bit     = ROW_W'(1) << c_q;
  assign cur_dead  = cur_q & ~c_bit;
  assign pcur_dead = pcur_q & ~c_bit;
  assign emit_last = (XW'(k_q) == n_x - XW'(1));

  assign stat_o.start_open = cur_q[0];
  assign stat_o.at_goal    = (r_x == n_x - XW'(1)) && (c_x == n_x - XW'(1));
  assign stat_o.can_down   = nxt_q[c_q];
  assign stat_o.can_right  = (c_q != '1) && cur_q[c_q + COL_W'(1)];
  assign stat_o.at_origin  = (r_q == '0) && (c_q == '0);
  assign stat_o.came_right = (c_q != '0) && pcur_q[c_q - COL_W'(1)];
  assign stat_o.emit_last  = emit_last;

  always_comb begin
    raddr  = '0;
    waddr  = r_q;
    mwe    = 1'b0;
    wwe    = 1'b0;
    pwe    = 1'b0;
    mwdata = cur_q;
    pwdata = pcur_q;
    unique case (op_i)
      mps_pkg::OP_LOAD: begin
        mwe    = (rowcnt_q < n);
        waddr  = rowcnt_q[RW-1:0];
        mwdata = row_open_i;
      end
      mps_pkg::OP_RD1: begin
        raddr = RW'(1);
      end
      mps_pkg::OP_DOWN: begin
        wwe   = 1'b1;
        pwe   = 1'b1;
        raddr = RW'(r_x + XW'(2));
      end
      mps_pkg::OP_BACK_UP: begin
        wwe    = 1'b1;
        pwe    = 1'b1;
        mwdata = cur_dead;
        pwdata = pcur_dead;
        raddr  = r_q - RW'(1);
      end
      mps_pkg::OP_GOAL: begin
        pwe = 1'b1;
      end
      mps_pkg::OP_PRD: begin
        raddr = k_q;
      end
      mps_pkg::OP_EMIT: begin
        raddr = k_q + RW'(1);
      end
      default: ;
    endcase
  end

  // working copy holds rows with dead ends cleared for the current search
  always_ff @(posedge clk_i) begin
    if (mwe) begin
      maze_mem[waddr] <= mwdata;
    end
    if (wwe) begin
      work_mem[waddr] <= mwdata;
    end
    if (pwe) begin
      path_mem[waddr] <= pwdata;
    end
    mrd_q <= maze_mem[raddr];
    wrd_q <= work_mem[raddr];
    prd_q <= path_mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gs_q      <= mps_pkg::GS_RESET;
      rowcnt_q  <= '0;
      r_q       <= '0;
      c_q       <= '0;
      k_q       <= '0;
      res_vld_q <= 1'b0;
      wvld_q    <= '0;
      wrd_vld_q <= 1'b0;
    end else begin
      res_vld_q <= 1'b0;
      wrd_vld_q <= wvld_q[raddr];
      if (cfg_we_i) begin
        gs_q <= grid_size_i;
      end
      unique case (op_i)
        mps_pkg::OP_LOAD: begin
          if (last_row_i) begin
            rowcnt_q <= '0;
            wvld_q   <= '0;
          end else if (rowcnt_q < n) begin
            rowcnt_q <= rowcnt_q + SZW'(1);
          end
        end
        mps_pkg::OP_RD2: begin
          r_q <= '0;
          c_q <= '0;
        end
        mps_pkg::OP_DOWN: begin
          r_q         <= r_q + RW'(1);
          wvld_q[r_q] <= 1'b1;
        end
        mps_pkg::OP_RIGHT:   c_q <= c_q + COL_W'(1);
        mps_pkg::OP_BACK_L:  c_q <= c_q - COL_W'(1);
        mps_pkg::OP_BACK_UP: begin
          r_q         <= r_q - RW'(1);
          wvld_q[r_q] <= 1'b1;
        end
        mps_pkg::OP_GOAL:    k_q <= '0;
        mps_pkg::OP_EMIT: begin
          k_q       <= k_q + RW'(1);
          res_vld_q <= 1'b1;
        end
        mps_pkg::OP_NF:      res_vld_q <= 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (op_i)
      mps_pkg::OP_RD1: cur_q <= mrd_m;
      mps_pkg::OP_RD2: begin
        nxt_q  <= (n_x > XW'(1)) ? mrd_m : '0;
        pcur_q <= ROW_W'(1);
      end
      mps_pkg::OP_DOWN: begin
        cur_q  <= nxt_q;
        pcur_q <= c_bit;
      end
      mps_pkg::OP_FILL_DN: nxt_q <= (r_x + XW'(1) < n_x) ? mrd_m : '0;
      mps_pkg::OP_RIGHT:   pcur_q <= pcur_q | (c_bit << 1);
      mps_pkg::OP_BACK_L: begin
        cur_q  <= cur_dead;
        pcur_q <= pcur_dead;
      end
      mps_pkg::OP_BACK_UP: nxt_q <= cur_dead;
      mps_pkg::OP_FILL_UP: begin
        cur_q  <= mrd_m;
        pcur_q <= prd_q;
      end
      mps_pkg::OP_EMIT: begin
        found_q <= 1'b1;
        path_q  <= prd_q;
        last_q  <= emit_last;
      end
      mps_pkg::OP_NF: begin
        found_q <= 1'b0;
        path_q  <= '0;
        last_q  <= 1'b1;
      end
      default: ;
    endcase
  end

  assign result_valid_o = res_vld_q;
  assign found_o        = found_q;
  assign path_row_o     = path_q;
  assign last_result_o  = last_q;

endmodule

@@ rtl/core/mps_ctrl.sv @@
// Controller: sequences row load, search moves and result output.
// Depends on mps_pkg; drives mps_datapath through dp_op_e commands.
module mps_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               last_row_i,
  input  mps_pkg::dp_stat_t  stat_i,
  output mps_pkg::dp_op_e    op_o,
  output logic               busy_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD0,
    S_RD1,
    S_RD2,
    S_SRCH,
    S_FILL_DN,
    S_FILL_UP,
    S_PRD,
    S_EMIT,
    S_NF
  } state_e;

  state_e state_q, state_d;
  logic   busy_q, busy_d;

  always_comb begin
    op_o    = mps_pkg::OP_NONE;
    state_d = state_q;
    busy_d  = busy_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          op_o = mps_pkg::OP_LOAD;
          if (last_row_i) begin
            state_d = S_RD0;
            busy_d  = 1'b1;
          end
        end
      end
      S_RD0: begin
        op_o    = mps_pkg::OP_RD0;
        state_d = S_RD1;
      end
      S_RD1: begin
        op_o    = mps_pkg::OP_RD1;
        state_d = S_RD2;
      end
      S_RD2: begin
        op_o    = mps_pkg::OP_RD2;
        state_d = stat_i.start_open ? S_SRCH : S_NF;
      end
      S_SRCH: begin
        priority if (stat_i.at_goal) begin
          op_o    = mps_pkg::OP_GOAL;
          state_d = S_PRD;
        end else if (stat_i.can_down) begin
          op_o    = mps_pkg::OP_DOWN;
          state_d = S_FILL_DN;
        end else if (stat_i.can_right) begin
          op_o = mps_pkg::OP_RIGHT;
        end else if (stat_i.at_origin) begin
          state_d = S_NF;
        end else if (stat_i.came_right) begin
          op_o = mps_pkg::OP_BACK_L;
        end else begin
          op_o    = mps_pkg::OP_BACK_UP;
          state_d = S_FILL_UP;
        end
      end
      S_FILL_DN: begin
        op_o    = mps_pkg::OP_FILL_DN;
        state_d = S_SRCH;
      end
      S_FILL_UP: begin
        op_o    = mps_pkg::OP_FILL_UP;
        state_d = S_SRCH;
      end
      S_PRD: begin
        op_o    = mps_pkg::OP_PRD;
        state_d = S_EMIT;
      end
      S_EMIT: begin
        op_o = mps_pkg::OP_EMIT;
        if (stat_i.emit_last) begin
          state_d = S_IDLE;
          busy_d  = 1'b0;
        end
      end
      S_NF: begin
        op_o    = mps_pkg::OP_NF;
        state_d = S_IDLE;
        busy_d  = 1'b0;
      end
      default: begin
        state_d = S_IDLE;
        busy_d  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      busy_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q  <= busy_d;
    end
  end

  assign busy_o = busy_q;

endmodule

@@ dv/maze_path_search_checker.sv @@
// Checker for maze_path_search: tracks row and grid size transfers, predicts
// the path masks and compares every result. Depends on mps_pkg only.
module maze_path_search_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic                      busy_i,
  input  logic [mps_pkg::ROW_W-1:0] row_open_i,
  input  logic                      last_row_i,
  input  logic                      cfg_valid_i,
  input  logic                      cfg_ready_i,
  input  logic [mps_pkg::GS_W-1:0]  grid_size_i,
  input  logic                      result_valid_i,
  input  logic                      found_i,
  input  logic [mps_pkg::ROW_W-1:0] path_row_i,
  input  logic                      last_result_i,
  output int unsigned               err_count_o,
  output int unsigned               pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ROW_W     = mps_pkg::ROW_W;
  localparam int unsigned GS_W      = mps_pkg::GS_W;
  localparam int unsigned NROWS     = mps_pkg::MAX_SIZE_DEF;
  localparam int unsigned MOVES_MAX = 2 * mps_pkg::MAX_SIZE_DEF;

  typedef struct packed {
    logic             found;
    logic [ROW_W-1:0] path_row;
    logic             last;
  } path_res_t;

  path_res_t        path_q[$];
  logic [GS_W-1:0]  size_reg;
  logic [ROW_W-1:0] maze_rows  [NROWS];
  logic [ROW_W-1:0] trail      [NROWS];
  logic [ROW_W-1:0] dead_cells [NROWS];
  int unsigned      rows_in;
  int unsigned      err_cnt;

  assign err_count_o = err_cnt;

  task automatic report_miss(input string what);
    err_cnt++;
    $display("%0t checker: %s", $time, what);
  endtask

  function automatic int unsigned side_len(input logic [GS_W-1:0] v);
    if (v == '0) return 1;
    if (v > NROWS) return NROWS;
    return 32'(v);
  endfunction

  function automatic bit enterable(input int unsigned r, input int unsigned c,
                                   input int unsigned n);
    if (r >= n || c >= n) return 1'b0;
    return maze_rows[r][c] && !dead_cells[r][c];
  endfunction

  // down first, then right; failed cells become dead ends
  function automatic bit trace_path(input int unsigned n);
    logic        came_right [MOVES_MAX];
    int unsigned r, c, depth;
    r = 0;
    c = 0;
    depth = 0;
    for (int k = 0; k < NROWS; k++) begin
      trail[k] = '0;
      dead_cells[k] = '0;
    end
    if (!enterable(0, 0, n)) return 1'b0;
    trail[0][0] = 1'b1;
    for (int g = 0; g < 4 * n * n + 4; g++) begin
      if (r == n - 1 && c == n - 1) return 1'b1;
      if (enterable(r + 1, c, n) && depth < MOVES_MAX) begin
        came_right[depth] = 1'b0;
        depth++;
        r++;
        trail[r][c] = 1'b1;
      end else if (enterable(r, c + 1, n) && depth < MOVES_MAX) begin
        came_right[depth] = 1'b1;
        depth++;
        c++;
        trail[r][c] = 1'b1;
      end else begin
        dead_cells[r][c] = 1'b1;
        trail[r][c] = 1'b0;
        if (depth == 0) return 1'b0;
        depth--;
        if (!came_right[depth]) begin
          if (r > 0) r--;
        end else begin
          if (c > 0) c--;
        end
      end
    end
    return 1'b0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    path_res_t   got, want;
    int unsigned n;
    if (!rst_ni) begin
      size_reg = mps_pkg::GS_RESET;
      rows_in = 0;
      err_cnt = 0;
      path_q.delete();
      for (int k = 0; k < NROWS; k++) maze_rows[k] = '0;
      pending_o <= 0;
    end else begin
      if (result_valid_i) begin
        got = '{found: found_i, path_row: path_row_i, last: last_result_i};
        if (path_q.size() == 0) begin
          report_miss($sformatf("unexpected result found=%0b row=%h last=%0b",
                                got.found, got.path_row, got.last));
        end else begin
          want = path_q.pop_front();
          if (got !== want)
            report_miss($sformatf("result found=%0b row=%h last=%0b, want %0b %h %0b",
                                  got.found, got.path_row, got.last,
                                  want.found, want.path_row, want.last));
        end
      end
      if (start_i && !busy_i) begin
        n = side_len(size_reg);
        if (rows_in < n) begin
          maze_rows[rows_in] = row_open_i;
          rows_in++;
        end
        if (last_row_i) begin
          rows_in = 0;
          if (trace_path(n)) begin
            for (int k = 0; k < n; k++)
              path_q.push_back('{found: 1'b1, path_row: trail[k], last: (k == n - 1)});
          end else begin
            path_q.push_back('{found: 1'b0, path_row: '0, last: 1'b1});
          end
        end
      end
      // a size written at the same edge applies to later rows
      if (cfg_valid_i && cfg_ready_i) size_reg = grid_size_i;
      pending_o <= path_q.size();
    end
  end

endmodule

@@ dv/tb_maze_path_search.sv @@
// Testbench top for maze_path_search: drives maze rows and grid sizes, with
// a watchdog; checking is done by maze_path_search_checker. Uses mps_pkg.
module tb_maze_path_search;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ROW_W       = mps_pkg::ROW_W;
  localparam int unsigned GS_W        = mps_pkg::GS_W;
  localparam int unsigned NROWS       = mps_pkg::MAX_SIZE_DEF;
  localparam int unsigned QUIET_LIMIT = 5000;

  logic             clk_i;
  logic             rst_ni;
  logic             start;
  logic             busy;
  logic [ROW_W-1:0] row_open_i;
  logic             last_row_i;
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  logic [GS_W-1:0]  grid_size_i;
  logic             result_valid_o;
  logic             found_o;
  logic [ROW_W-1:0] path_row_o;
  logic             last_result_o;
  int unsigned      err_count;
  int unsigned      pending;

  logic [ROW_W-1:0] maze_buf [NROWS];
  logic [GS_W-1:0]  cur_size;
  int unsigned      idle_pct;
  int unsigned      rows_sent;

  maze_path_search u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .row_open_i    (row_open_i),
    .last_row_i    (last_row_i),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .grid_size_i   (grid_size_i),
    .result_valid_o(result_valid_o),
    .found_o       (found_o),
    .path_row_o    (path_row_o),
    .last_result_o (last_result_o)
  );

  maze_path_search_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .busy_i        (busy),
    .row_open_i    (row_open_i),
    .last_row_i    (last_row_i),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .grid_size_i   (grid_size_i),
    .result_valid_i(result_valid_o),
    .found_i       (found_o),
    .path_row_i    (path_row_o),
    .last_result_i (last_result_o),
    .err_count_o   (err_count),
    .pending_o     (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((start && !busy) || (cfg_valid_i && cfg_ready_o) || result_valid_o) quiet = 0;
      else quiet++;
    end
    $display("tb: failure");
    $finish;
  end

  task automatic send_row(input logic [ROW_W-1:0] r, input logic l);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      row_open_i <= ROW_W'($urandom);
      last_row_i <= 1'($urandom);
      @(posedge clk_i);
    end
    start <= 1'b1;
    row_open_i <= r;
    last_row_i <= l;
    rows_sent++;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0 || busy) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_size(input logic [GS_W-1:0] v);
    wait_idle();
    cfg_valid_i <= 1'b1;
    grid_size_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    cur_size = v;
  endtask

  function automatic logic [GS_W-1:0] pick_size();
    case ($urandom_range(9))
      0, 1, 2, 3: return GS_W'($urandom_range(1, 5));
      4, 5:       return GS_W'($urandom_range(6, 15));
      6:          return 5'd16;
      7:          return 5'd0;
      8:          return GS_W'($urandom_range(17, 31));
      default:    return GS_W'($urandom_range(0, 31));
    endcase
  endfunction

  // random density, optionally with a carved monotone route to the goal
  function automatic void build_maze(input int unsigned n, input bit carve);
    int unsigned r, c;
    for (int k = 0; k < NROWS; k++) begin
      case ($urandom_range(2))
        0:       maze_buf[k] = ROW_W'($urandom);
        1:       maze_buf[k] = ROW_W'($urandom | $urandom);
        default: maze_buf[k] = ROW_W'($urandom & $urandom);
      endcase
    end
    if (carve) begin
      r = 0;
      c = 0;
      maze_buf[0][0] = 1'b1;
      while (r < n - 1 || c < n - 1) begin
        if (r == n - 1) c++;
        else if (c == n - 1) r++;
        else if ($urandom_range(1)) r++;
        else c++;
        maze_buf[r][c] = 1'b1;
      end
    end
  endfunction

  task automatic send_maze();
    int unsigned n, kind, rows;
    bit          done;
    n = (cur_size == 0) ? 1 : ((cur_size > NROWS) ? NROWS : 32'(cur_size));
    kind = $urandom_range(9);
    if (kind <= 7) begin
      build_maze(n, $urandom_range(9) < 8);
      if (kind <= 5) rows = n;
      else if (kind == 6) rows = n + $urandom_range(1, 3);
      else rows = $urandom_range(1, n);
      for (int k = 0; k < rows; k++)
        send_row((k < NROWS) ? maze_buf[k] : ROW_W'($urandom), k == rows - 1);
    end else begin
      done = 1'b0;
      for (int k = 0; k < 20 && !done; k++) begin
        done = ($urandom_range(3) == 0) || (k == 19);
        send_row(ROW_W'($urandom), done);
      end
    end
  endtask

  initial begin
    int unsigned targets [3];
    int unsigned idles [3];
    targets = '{150, 250, 350};
    idles = '{36, 86, 0};
    rst_ni <= 1'b0;
    start <= 1'b0;
    row_open_i <= '0;
    last_row_i <= 1'b0;
    cfg_valid_i <= 1'b0;
    grid_size_i <= '0;
    cur_size = mps_pkg::GS_RESET;
    rows_sent = 0;
    idle_pct = idles[0];
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // full 16x16 open maze first, so every row is written
    for (int k = 0; k < NROWS; k++) send_row(16'hFFFF, k == NROWS - 1);
    write_size(5'd1);
    send_row(16'h0001, 1'b1);
    send_row(16'hFFFE, 1'b1);   // closed start
    write_size(5'd0);
    send_row(16'hFFFF, 1'b1);
    write_size(5'd2);
    send_row(16'h0003, 1'b0);
    send_row(16'h0003, 1'b0);
    send_row(16'hFFFF, 1'b0);   // extra rows, ignored
    send_row(16'hFFFF, 1'b1);
    send_row(16'h0003, 1'b0);
    send_row(16'h0001, 1'b1);   // closed goal
    write_size(5'd3);
    send_row(16'h0007, 1'b1);   // short maze, rows 1 and 2 kept
    send_row(16'h0007, 1'b0);   // dead end below, then around to the right
    send_row(16'h0005, 1'b0);
    send_row(16'h0006, 1'b1);

    for (int p = 0; p < 3; p++) begin
      idle_pct = idles[p];
      write_size(pick_size());
      while (rows_sent < targets[p]) begin
        if ($urandom_range(3) == 0) write_size(pick_size());
        send_maze();
      end
    end

    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0 || busy) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (err_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/mps_pkg.sv
rtl/core/mps_datapath.sv
rtl/core/mps_ctrl.sv
rtl/core/maze_path_search.sv
dv/maze_path_search_checker.sv
dv/tb_maze_path_search.sv
